// ===== rtl/sbc_pkg.sv =====
// ============================================================================
// sbc_pkg
// Shared types and constants for the small batch coalescer.
// ============================================================================
package sbc_pkg;

    localparam int unsigned ROW_W       = 12;
    localparam int unsigned ST_W        = 2;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned VECTOR_SIZE = 2048;
    localparam int unsigned SUM_W       = ROW_W + 1;

    typedef logic [ROW_W-1:0]  rows_t;
    typedef logic [ST_W-1:0]   status_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam status_t ST_NEED_INPUT = 2'd0;
    localparam status_t ST_HAVE_MORE  = 2'd1;
    localparam status_t ST_FINISHED   = 2'd2;
    localparam status_t ST_BLOCKED    = 2'd3;

    localparam mode_t MODE_NONE        = 2'd0;
    localparam mode_t MODE_PARTITIONED = 2'd1;
    localparam mode_t MODE_ORDERED     = 2'd2;
    localparam mode_t MODE_UNORDERED   = 2'd3;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic    kind;
        rows_t   rows;
        status_t status;
        logic    fits_cache;
        logic    needs_cont;
        logic    mode_none;
        logic    mode_unord;
    } cls_word_t;

    typedef enum logic [2:0] {
        ACT_PASS,
        ACT_APPEND,
        ACT_CACHED_PLUS,
        ACT_CACHED_THEN_APPEND,
        ACT_VIA_CONT,
        ACT_CACHE_ONLY
    } action_t;

endpackage

// ===== rtl/sbc_in_if.sv =====
// ============================================================================
// sbc_in_if
// Input channel: batch report or flush word with valid/ready handshake.
// ============================================================================
interface sbc_in_if;

    logic                valid;
    logic                ready;
    logic                kind;
    sbc_pkg::rows_t      batch_rows;
    sbc_pkg::status_t    upstream_status;

    modport source (output valid, output kind, output batch_rows,
                    output upstream_status, input ready);
    modport sink   (input valid, input kind, input batch_rows,
                    input upstream_status, output ready);

endinterface

// ===== rtl/sbc_out_if.sv =====
// ============================================================================
// sbc_out_if
// Output channel: returned batch word with valid/ready handshake.
// ============================================================================
interface sbc_out_if;

    logic                valid;
    logic                ready;
    sbc_pkg::rows_t      out_rows;
    sbc_pkg::rows_t      cached_part_rows;
    sbc_pkg::status_t    out_status;
    logic                pending_after;
    sbc_pkg::rows_t      cache_rows_after;

    modport source (output valid, output out_rows, output cached_part_rows,
                    output out_status, output pending_after,
                    output cache_rows_after, input ready);
    modport sink   (input valid, input out_rows, input cached_part_rows,
                    input out_status, input pending_after,
                    input cache_rows_after, output ready);

endinterface

// ===== rtl/small_batch_coalescer.sv =====
// ============================================================================
// small_batch_coalescer
// Coalesces small row batches into a row cache, with continuation handling.
// ============================================================================
// Path: an accepted input word is held in a queue entry, then in the output
// register, which raises output valid; the word can wait in the queue while out_ch.ready is low.
// Throughput: one word per cycle while out_ch.ready stays high; the cache update loop sets it.
// Reset: asynchronous, clears cache count, continuation flag, held status,
// queue and output valid; mode resets to none and threshold to 64.
module small_batch_coalescer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  sbc_pkg::rows_t  cfg_data,
    sbc_in_if.sink          in_ch,
    sbc_out_if.source       out_ch
);
    import sbc_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    cls_word_t  q_wdata;
    cls_word_t  q_rdata;

    sbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    sbc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    sbc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// ===== rtl/sbc_front.sv =====
// ============================================================================
// sbc_front
// Configuration registers and classification of incoming words.
// ============================================================================
module sbc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  sbc_pkg::rows_t      cfg_data,
    sbc_in_if.sink              in_ch,
    input  logic                q_full,
    output logic                q_push,
    output sbc_pkg::cls_word_t  q_wdata
);
    import sbc_pkg::*;

    mode_t mode_reg;
    rows_t threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            threshold_reg <= ROW_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    always_comb
    begin
        q_wdata.kind       = in_ch.kind;
        q_wdata.rows       = in_ch.batch_rows;
        q_wdata.status     = in_ch.upstream_status;
        q_wdata.fits_cache = in_ch.batch_rows <= threshold_reg;
        q_wdata.needs_cont = (mode_reg == MODE_PARTITIONED &&
                              in_ch.upstream_status != ST_HAVE_MORE) ||
                             in_ch.upstream_status == ST_FINISHED;
        q_wdata.mode_none  = mode_reg == MODE_NONE;
        q_wdata.mode_unord = mode_reg == MODE_UNORDERED;
    end

endmodule

// ===== rtl/sbc_queue.sv =====
// ============================================================================
// sbc_queue
// Two-entry queue of classified words between front and back.
// ============================================================================
module sbc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sbc_pkg::cls_word_t  wdata,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output sbc_pkg::cls_word_t  rdata
);
    import sbc_pkg::*;

    cls_word_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/sbc_back.sv =====
// ============================================================================
// sbc_back
// Cache state, coalescing decision and output register.
// ============================================================================
module sbc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  sbc_pkg::cls_word_t  q_rdata,
    output logic                q_pop,
    sbc_out_if.source           out_ch
);
    import sbc_pkg::*;

    rows_t      cached_reg;
    rows_t      cached_next;
    logic       pend_reg;
    logic       pend_next;
    status_t    held_reg;
    status_t    held_next;

    logic       out_valid_reg;
    rows_t      out_rows_reg;
    rows_t      out_rows_next;
    rows_t      out_part_reg;
    rows_t      out_part_next;
    status_t    out_status_reg;
    status_t    out_status_next;
    logic       out_pend_reg;
    rows_t      out_cache_reg;

    logic [SUM_W-1:0] sum;
    logic       has_cached;
    logic       has_space;
    logic       zero_rows;
    action_t    act;

    assign q_pop = !q_empty && (!out_valid_reg || out_ch.ready);

    assign sum        = {1'b0, cached_reg} + {1'b0, q_rdata.rows};
    assign has_cached = cached_reg != '0;
    assign has_space  = 32'(sum) <= VECTOR_SIZE;
    assign zero_rows  = q_rdata.rows == '0;

    always_comb
    begin
        act = ACT_PASS;
        if (has_cached && q_rdata.needs_cont)
        begin
            if (zero_rows)
                act = (q_rdata.status == ST_BLOCKED) ? ACT_VIA_CONT : ACT_CACHE_ONLY;
            else if (q_rdata.fits_cache && has_space)
                act = ACT_CACHED_PLUS;
            else
                act = ACT_VIA_CONT;
        end
        else if (zero_rows)
            act = ACT_PASS;
        else if (q_rdata.fits_cache && !q_rdata.needs_cont)
            act = has_space ? ACT_APPEND : ACT_CACHED_THEN_APPEND;
        else if (q_rdata.mode_unord)
            act = ACT_PASS;
        else if (has_cached)
        begin
            if (!q_rdata.fits_cache)
                act = ACT_VIA_CONT;
            else if (has_space)
                act = ACT_CACHED_PLUS;
            else if (q_rdata.needs_cont)
                act = ACT_VIA_CONT;
            else
                act = ACT_CACHED_THEN_APPEND;
        end
    end

    always_comb
    begin
        cached_next     = cached_reg;
        pend_next       = pend_reg;
        held_next       = held_reg;
        out_rows_next   = q_rdata.rows;
        out_part_next   = '0;
        out_status_next = q_rdata.status;
        if (q_rdata.kind == KIND_FLUSH)
        begin
            cached_next     = '0;
            pend_next       = 1'b0;
            held_next       = ST_NEED_INPUT;
            out_rows_next   = cached_reg;
            out_part_next   = cached_reg;
            out_status_next = ST_FINISHED;
        end
        else if (pend_reg)
        begin
            cached_next   = '0;
            out_rows_next = cached_reg;
            if (held_reg == ST_BLOCKED && has_cached)
                out_status_next = ST_HAVE_MORE;
            else
            begin
                pend_next       = 1'b0;
                out_status_next = held_reg;
            end
        end
        else if (!q_rdata.mode_none)
        begin
            case (act)
                ACT_PASS:
                begin
                    out_rows_next = q_rdata.rows;
                end
                ACT_APPEND:
                begin
                    cached_next   = sum[ROW_W-1:0];
                    out_rows_next = '0;
                end
                ACT_CACHED_PLUS:
                begin
                    cached_next   = '0;
                    out_rows_next = sum[ROW_W-1:0];
                    out_part_next = cached_reg;
                end
                ACT_CACHED_THEN_APPEND:
                begin
                    cached_next   = q_rdata.rows;
                    out_rows_next = cached_reg;
                    out_part_next = cached_reg;
                end
                ACT_VIA_CONT:
                begin
                    cached_next     = q_rdata.rows;
                    pend_next       = 1'b1;
                    held_next       = q_rdata.status;
                    out_rows_next   = cached_reg;
                    out_part_next   = cached_reg;
                    out_status_next = ST_HAVE_MORE;
                end
                ACT_CACHE_ONLY:
                begin
                    cached_next   = '0;
                    out_rows_next = cached_reg;
                    out_part_next = cached_reg;
                end
                default:
                begin
                    out_rows_next = q_rdata.rows;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cached_reg    <= '0;
            pend_reg      <= 1'b0;
            held_reg      <= ST_NEED_INPUT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cached_reg    <= cached_next;
                pend_reg      <= pend_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_rows_reg   <= out_rows_next;
            out_part_reg   <= out_part_next;
            out_status_reg <= out_status_next;
            out_pend_reg   <= pend_next;
            out_cache_reg  <= cached_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.out_rows         = out_rows_reg;
    assign out_ch.cached_part_rows = out_part_reg;
    assign out_ch.out_status       = out_status_reg;
    assign out_ch.pending_after    = out_pend_reg;
    assign out_ch.cache_rows_after = out_cache_reg;

`ifndef SYNTHESIS
    a_pend_have_more: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pend_reg) |-> out_status_reg == ST_HAVE_MORE)
        else $error("continuation without have-more status");
    a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_pend_reg == pend_reg && out_cache_reg == cached_reg)
        else $error("output word disagrees with cache state");
`endif

endmodule
